// ===== sv/poa_pkg.sv =====
package poa_pkg;

  localparam int KEY_BITS     = 23;
  localparam int YEAR_BITS    = 14;
  localparam int MONTH_BITS   = 4;
  localparam int DAY_BITS     = 5;
  localparam int GRAN_BITS    = 2;
  localparam int COUNTRY_BITS = 5;

  localparam int SAMPLE_BITS_DEFAULT = 16;
  localparam int COUNT_BITS_DEFAULT  = 16;

  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_GRANULARITY = 2'd0;
  localparam logic [1:0] REG_START_KEY   = 2'd1;
  localparam logic [1:0] REG_END_KEY     = 2'd2;
  localparam logic [1:0] REG_COUNTRY     = 2'd3;

  localparam logic [GRAN_BITS-1:0] GRAN_YEAR  = 2'd0;
  localparam logic [GRAN_BITS-1:0] GRAN_MONTH = 2'd1;
  localparam logic [GRAN_BITS-1:0] GRAN_DAY   = 2'd2;

  localparam logic [KEY_BITS-1:0] START_KEY_RESET = 23'd0;
  localparam logic [KEY_BITS-1:0] END_KEY_RESET   = 23'd5119903;

  typedef struct packed {
    logic set_open;
    logic fold;
    logic fresh;
    logic div_start;
    logic emit;
    logic last_flag;
    logic set_stop;
    logic clear_all;
  } poa_cmd_t;

  typedef struct packed {
    logic stopped;
    logic below;
    logic above;
    logic have;
    logic changed;
    logic eod;
    logic div_done;
    logic out_free;
  } poa_sts_t;

endpackage

// ===== sv/period_ohlc_aggregator_top.sv =====
// Candle aggregator: each request on the slave stream is one dated row (low, high and
// mean sample, signed fixed point); each request on the master stream is one candle
// (open, high, low, close), and tlast marks the last candle of a data set. A new row is
// taken only while the block is idle, so a row that closes a candle (at most two per row)
// holds the input until its candles are in the output register; the close is the period's
// mean sum divided by its row count in a radix-2 divider that develops one quotient bit
// per cycle. One finished candle may wait in the output register while the next row is
// taken in. Registers sit on the APB port at byte addresses 0 (granularity), 4 (start key),
// 8 (end key) and 12 (country code); the user must write them only while the block is idle,
// and the block itself does not enforce this.
module period_ohlc_aggregator_top
  import poa_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
  parameter int COUNT_BITS  = COUNT_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // year, month, day, low_value, high_value, mean_value
  input  logic [((KEY_BITS + 3*SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                     s_tlast,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // period_key, open_value, high_out, low_out, close_value, country
  output logic [((KEY_BITS + 4*SAMPLE_BITS + COUNTRY_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  output logic                     m_tlast,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int IN_LOW   = KEY_BITS;
  localparam int IN_HIGH  = IN_LOW + SAMPLE_BITS;
  localparam int IN_MEAN  = IN_HIGH + SAMPLE_BITS;
  localparam int OUT_OPEN  = KEY_BITS;
  localparam int OUT_HIGH  = OUT_OPEN + SAMPLE_BITS;
  localparam int OUT_LOW   = OUT_HIGH + SAMPLE_BITS;
  localparam int OUT_CLOSE = OUT_LOW + SAMPLE_BITS;
  localparam int OUT_CTRY  = OUT_CLOSE + SAMPLE_BITS;

  logic [GRAN_BITS-1:0]    granularity;
  logic [KEY_BITS-1:0]     start_key;
  logic [KEY_BITS-1:0]     end_key;
  logic [COUNTRY_BITS-1:0] country_code;
  logic                    cfg_write;

  poa_cmd_t cmd;
  poa_sts_t sts;

  logic [KEY_BITS-1:0]     period_key;
  logic [SAMPLE_BITS-1:0]  open_value;
  logic [SAMPLE_BITS-1:0]  high_out;
  logic [SAMPLE_BITS-1:0]  low_out;
  logic [SAMPLE_BITS-1:0]  close_value;
  logic [COUNTRY_BITS-1:0] country;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      granularity  <= GRAN_DAY;
      start_key    <= START_KEY_RESET;
      end_key      <= END_KEY_RESET;
      country_code <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_GRANULARITY: granularity  <= pwdata[GRAN_BITS-1:0];
        REG_START_KEY:   start_key    <= pwdata[KEY_BITS-1:0];
        REG_END_KEY:     end_key      <= pwdata[KEY_BITS-1:0];
        REG_COUNTRY:     country_code <= pwdata[COUNTRY_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GRANULARITY: prdata = CFG_DATA_BITS'(granularity);
      REG_START_KEY:   prdata = CFG_DATA_BITS'(start_key);
      REG_END_KEY:     prdata = CFG_DATA_BITS'(end_key);
      REG_COUNTRY:     prdata = CFG_DATA_BITS'(country_code);
      default:         prdata = '0;
    endcase
  end

  poa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .sts     (sts),
    .in_ready(s_tready),
    .cmd     (cmd)
  );

  poa_dp #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .item_load   (s_tvalid && s_tready),
    .year        (s_tdata[YEAR_BITS-1:0]),
    .month       (s_tdata[YEAR_BITS+MONTH_BITS-1:YEAR_BITS]),
    .day         (s_tdata[KEY_BITS-1:YEAR_BITS+MONTH_BITS]),
    .low_value   (s_tdata[IN_HIGH-1:IN_LOW]),
    .high_value  (s_tdata[IN_MEAN-1:IN_HIGH]),
    .mean_value  (s_tdata[IN_MEAN+SAMPLE_BITS-1:IN_MEAN]),
    .end_of_data (s_tlast),
    .granularity (granularity),
    .start_key   (start_key),
    .end_key     (end_key),
    .country_code(country_code),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .period_key  (period_key),
    .open_value  (open_value),
    .high_out    (high_out),
    .low_out     (low_out),
    .close_value (close_value),
    .country     (country),
    .final_candle(m_tlast)
  );

  always_comb begin
    m_tdata = '0;
    m_tdata[KEY_BITS-1:0]                 = period_key;
    m_tdata[OUT_HIGH-1:OUT_OPEN]          = open_value;
    m_tdata[OUT_LOW-1:OUT_HIGH]           = high_out;
    m_tdata[OUT_CLOSE-1:OUT_LOW]          = low_out;
    m_tdata[OUT_CTRY-1:OUT_CLOSE]         = close_value;
    m_tdata[OUT_CTRY+COUNTRY_BITS-1:OUT_CTRY] = country;
  end

endmodule

// ===== sv/poa_div.sv =====
module poa_div
  import poa_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
  parameter int COUNT_BITS  = COUNT_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [SAMPLE_BITS+COUNT_BITS-1:0] dividend,
  input  logic [COUNT_BITS-1:0]             divisor,
  output logic                              done,
  output logic [SAMPLE_BITS-1:0]            quotient
);

  localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
  localparam int STEP_BITS = $clog2(SAMPLE_BITS + 1);

  logic                   busy;
  logic [STEP_BITS-1:0]   steps;
  logic                   neg;
  logic                   zero_div;
  logic [COUNT_BITS-1:0]  divisor_q;
  logic [COUNT_BITS-1:0]  rem;
  logic [SAMPLE_BITS-1:0] shreg;
  logic [SUM_BITS-1:0]    mag;
  logic [COUNT_BITS+1:0]  diff;

  assign mag  = dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
  assign diff = {1'b0, rem, shreg[SAMPLE_BITS-1]} - {2'b00, divisor_q};

  // The quotient magnitude never exceeds the largest sample magnitude, so the
  // upper dividend bits are already below the divisor and only SAMPLE_BITS
  // quotient bits have to be developed.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_BITS'(SAMPLE_BITS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg       <= dividend[SUM_BITS-1];
      zero_div  <= (divisor == '0);
      divisor_q <= divisor;
      rem       <= mag[SUM_BITS-1:SAMPLE_BITS];
      shreg     <= mag[SAMPLE_BITS-1:0];
    end else if (busy) begin
      if (!diff[COUNT_BITS+1]) begin
        rem <= diff[COUNT_BITS-1:0];
      end else begin
        rem <= {rem[COUNT_BITS-2:0], shreg[SAMPLE_BITS-1]};
      end
      shreg <= {shreg[SAMPLE_BITS-2:0], ~diff[COUNT_BITS+1]};
    end
  end

  assign quotient = zero_div ? '0 : (neg ? (~shreg + 1'b1) : shreg);

endmodule

// ===== sv/poa_dp.sv =====
module poa_dp
  import poa_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
  parameter int COUNT_BITS  = COUNT_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_load,
  input  logic [YEAR_BITS-1:0]          year,
  input  logic [MONTH_BITS-1:0]         month,
  input  logic [DAY_BITS-1:0]           day,
  input  logic signed [SAMPLE_BITS-1:0] low_value,
  input  logic signed [SAMPLE_BITS-1:0] high_value,
  input  logic signed [SAMPLE_BITS-1:0] mean_value,
  input  logic                          end_of_data,
  input  logic [GRAN_BITS-1:0]          granularity,
  input  logic [KEY_BITS-1:0]           start_key,
  input  logic [KEY_BITS-1:0]           end_key,
  input  logic [COUNTRY_BITS-1:0]       country_code,
  input  poa_cmd_t                      cmd,
  output poa_sts_t                      sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [KEY_BITS-1:0]           period_key,
  output logic [SAMPLE_BITS-1:0]        open_value,
  output logic [SAMPLE_BITS-1:0]        high_out,
  output logic [SAMPLE_BITS-1:0]        low_out,
  output logic [SAMPLE_BITS-1:0]        close_value,
  output logic [COUNTRY_BITS-1:0]       country,
  output logic                          final_candle
);

  localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [KEY_BITS-1:0]           key_in;
  logic [KEY_BITS-1:0]           item_key;
  logic signed [SAMPLE_BITS-1:0] item_low;
  logic signed [SAMPLE_BITS-1:0] item_high;
  logic signed [SAMPLE_BITS-1:0] item_mean;
  logic                          item_eod;

  logic [SAMPLE_BITS-1:0]        open_mean;
  logic [KEY_BITS-1:0]           current_key;
  logic                          have_period;
  logic signed [SAMPLE_BITS-1:0] low_so_far;
  logic signed [SAMPLE_BITS-1:0] high_so_far;
  logic [SUM_BITS-1:0]           mean_sum;
  logic [COUNT_BITS-1:0]         row_count;
  logic                          stopped;

  logic [SUM_BITS-1:0]           mean_ext;
  logic [SAMPLE_BITS-1:0]        close;
  logic                          div_done;

  always_comb begin
    case (granularity)
      GRAN_YEAR:  key_in = {year, {(MONTH_BITS + DAY_BITS){1'b0}}};
      GRAN_MONTH: key_in = {year, month, {DAY_BITS{1'b0}}};
      default:    key_in = {year, month, day};
    endcase
  end

  always_ff @(posedge clk) begin
    if (item_load) begin
      item_key  <= key_in;
      item_low  <= low_value;
      item_high <= high_value;
      item_mean <= mean_value;
      item_eod  <= end_of_data;
    end
  end

  assign mean_ext = {{COUNT_BITS{item_mean[SAMPLE_BITS-1]}}, item_mean};

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      open_mean   <= '0;
      current_key <= '0;
      have_period <= 1'b0;
      low_so_far  <= SAMPLE_MAX;
      high_so_far <= SAMPLE_MIN;
      mean_sum    <= '0;
      row_count   <= '0;
      stopped     <= 1'b0;
    end else begin
      if (cmd.set_open) begin
        open_mean <= item_mean;
      end
      if (cmd.set_stop) begin
        stopped <= 1'b1;
      end
      if (cmd.fold) begin
        current_key <= item_key;
        have_period <= 1'b1;
        if (cmd.fresh) begin
          // A new period opens on the close of the one just emitted.
          open_mean   <= close;
          low_so_far  <= item_low;
          high_so_far <= item_high;
          mean_sum    <= mean_ext;
          row_count   <= COUNT_BITS'(1);
        end else begin
          if (item_low < low_so_far) begin
            low_so_far <= item_low;
          end
          if (item_high > high_so_far) begin
            high_so_far <= item_high;
          end
          if (row_count != '1) begin
            mean_sum  <= mean_sum + mean_ext;
            row_count <= row_count + 1'b1;
          end
        end
      end
    end
  end

  poa_div #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(mean_sum),
    .divisor (row_count),
    .done    (div_done),
    .quotient(close)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      period_key   <= current_key;
      open_value   <= open_mean;
      high_out     <= high_so_far;
      low_out      <= low_so_far;
      close_value  <= close;
      country      <= country_code;
      final_candle <= cmd.last_flag;
    end
  end

  always_comb begin
    sts.stopped  = stopped;
    sts.below    = item_key < start_key;
    sts.above    = item_key > end_key;
    sts.have     = have_period;
    sts.changed  = item_key != current_key;
    sts.eod      = item_eod;
    sts.div_done = div_done;
    sts.out_free = !out_valid || out_ready;
  end

endmodule

// ===== sv/poa_ctrl.sv =====
module poa_ctrl
  import poa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  poa_sts_t sts,
  output logic     in_ready,
  output poa_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_FOLD,
    S_DIV,
    S_EMIT,
    S_POST
  } state_t;

  // What follows once the pending candle has been handed to the output.
  typedef enum logic [1:0] {
    P_CLEAR,
    P_STOP,
    P_FRESH
  } post_t;

  state_t state;
  post_t  post;
  logic   last_flag;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      post      <= P_CLEAR;
      last_flag <= 1'b0;
      cmd       <= '0;
    end else begin
      cmd <= '0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          state <= S_IDLE;
          if (sts.stopped) begin
            cmd.clear_all <= sts.eod;
          end else if (sts.below) begin
            if (sts.eod && sts.have) begin
              last_flag     <= 1'b1;
              post          <= P_CLEAR;
              cmd.div_start <= 1'b1;
              state         <= S_DIV;
            end else if (sts.eod) begin
              cmd.clear_all <= 1'b1;
            end else if (!sts.have) begin
              cmd.set_open <= 1'b1;
            end
          end else if (sts.above) begin
            if (sts.have) begin
              last_flag     <= 1'b1;
              post          <= sts.eod ? P_CLEAR : P_STOP;
              cmd.div_start <= 1'b1;
              state         <= S_DIV;
            end else if (sts.eod) begin
              cmd.clear_all <= 1'b1;
            end else begin
              cmd.set_stop <= 1'b1;
            end
          end else if (sts.have && sts.changed) begin
            last_flag     <= 1'b0;
            post          <= P_FRESH;
            cmd.div_start <= 1'b1;
            state         <= S_DIV;
          end else begin
            cmd.fold <= 1'b1;
            state    <= S_FOLD;
          end
        end
        S_FOLD: begin
          if (sts.eod) begin
            last_flag     <= 1'b1;
            post          <= P_CLEAR;
            cmd.div_start <= 1'b1;
            state         <= S_DIV;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (sts.div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (sts.out_free) begin
            cmd.emit      <= 1'b1;
            cmd.last_flag <= last_flag;
            state         <= S_POST;
          end
        end
        S_POST: begin
          case (post)
            P_CLEAR: begin
              cmd.clear_all <= 1'b1;
              state         <= S_IDLE;
            end
            P_STOP: begin
              cmd.set_stop <= 1'b1;
              state        <= S_IDLE;
            end
            P_FRESH: begin
              cmd.fold  <= 1'b1;
              cmd.fresh <= 1'b1;
              state     <= S_FOLD;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.set_open, cmd.fold, cmd.div_start, cmd.emit, cmd.set_stop, cmd.clear_all}))
    else $error("more than one datapath command in a cycle");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> $past(sts.out_free))
    else $error("candle loaded while the output register was still full");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == S_DIV))
    else $error("divider finished outside the wait state");

endmodule

// ===== sim/period_ohlc_checker.sv =====
`timescale 1ns / 1ps
module period_ohlc_checker
  import poa_pkg::*;
#(
  parameter int SB = SAMPLE_BITS_DEFAULT,
  parameter int CB = COUNT_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  // year, month, day, low_value, high_value, mean_value
  input  logic [((KEY_BITS + 3*SB + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                     s_tlast,
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  // period_key, open_value, high_out, low_out, close_value, country
  input  logic [((KEY_BITS + 4*SB + COUNTRY_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  input  logic                     m_tlast,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  input  logic                     pready,
  input  logic                     finish_run,
  output int                       fail_count,
  output int                       pending,
  output int                       candles_seen
);

  localparam logic signed [SB-1:0] SAMPLE_TOP    = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SAMPLE_BOTTOM = {1'b1, {(SB-1){1'b0}}};
  localparam int MAX_PRINTED = 40;

  localparam int MONTH_LSB = YEAR_BITS;
  localparam int DAY_LSB   = YEAR_BITS + MONTH_BITS;
  localparam int LOW_LSB   = KEY_BITS;
  localparam int HIGH_LSB  = KEY_BITS + SB;
  localparam int MEAN_LSB  = KEY_BITS + 2*SB;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic signed [SB-1:0]    open_v;
    logic signed [SB-1:0]    high_v;
    logic signed [SB-1:0]    low_v;
    logic signed [SB-1:0]    close_v;
    logic [COUNTRY_BITS-1:0] country;
    logic                    last;
  } candle_t;

  candle_t pending_candles[$];
  candle_t want;

  logic [GRAN_BITS-1:0]    gran_cfg;
  logic [KEY_BITS-1:0]     start_cfg;
  logic [KEY_BITS-1:0]     end_cfg;
  logic [COUNTRY_BITS-1:0] country_cfg;

  logic signed [SB-1:0]    open_mean;
  logic [KEY_BITS-1:0]     cur_key;
  logic                    have_period;
  logic                    stopped;
  logic signed [SB-1:0]    low_acc;
  logic signed [SB-1:0]    high_acc;
  logic signed [SB+CB-1:0] mean_sum;
  logic [CB-1:0]           row_count;

  logic [YEAR_BITS-1:0]    row_year;
  logic [MONTH_BITS-1:0]   row_month;
  logic [DAY_BITS-1:0]     row_day;
  logic signed [SB-1:0]    row_low;
  logic signed [SB-1:0]    row_high;
  logic signed [SB-1:0]    row_mean;
  logic                    row_last;
  logic [KEY_BITS-1:0]     row_key;
  bit                      flushed;

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTED) $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val) begin
      report($sformatf("candle %0d: %s is %h, expected %h", candles_seen, name, got, exp_val));
    end
  endtask

  // Mean of the period's row means, truncated toward zero.
  function automatic logic [SB-1:0] period_close();
    longint q;
    if (row_count == 0) return '0;
    q = longint'(mean_sum) / longint'(row_count);
    return q[SB-1:0];
  endfunction

  task automatic clear_acc();
    low_acc = SAMPLE_TOP;
    high_acc = SAMPLE_BOTTOM;
    mean_sum = '0;
    row_count = '0;
  endtask

  task automatic clear_period();
    open_mean = '0;
    cur_key = '0;
    have_period = 1'b0;
    stopped = 1'b0;
    clear_acc();
  endtask

  task automatic push_candle(input logic last);
    candle_t c;
    c.key = cur_key;
    c.open_v = open_mean;
    c.high_v = high_acc;
    c.low_v = low_acc;
    c.close_v = period_close();
    c.country = country_cfg;
    c.last = last;
    pending_candles = {pending_candles, c};
  endtask

  always @(posedge clk) begin
    if (rst) begin
      gran_cfg = GRAN_DAY;
      start_cfg = START_KEY_RESET;
      end_cfg = END_KEY_RESET;
      country_cfg = '0;
      clear_period();
      pending_candles.delete();
      flushed = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_GRANULARITY: gran_cfg = pwdata[GRAN_BITS-1:0];
          REG_START_KEY:   start_cfg = pwdata[KEY_BITS-1:0];
          REG_END_KEY:     end_cfg = pwdata[KEY_BITS-1:0];
          REG_COUNTRY:     country_cfg = pwdata[COUNTRY_BITS-1:0];
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        row_year = s_tdata[0 +: YEAR_BITS];
        row_month = s_tdata[MONTH_LSB +: MONTH_BITS];
        row_day = s_tdata[DAY_LSB +: DAY_BITS];
        row_low = s_tdata[LOW_LSB +: SB];
        row_high = s_tdata[HIGH_LSB +: SB];
        row_mean = s_tdata[MEAN_LSB +: SB];
        row_last = s_tlast;
        if (stopped) begin
          // Past the end key: rows are dropped until the end of the data set.
          if (row_last) clear_period();
        end else begin
          case (gran_cfg)
            GRAN_YEAR:  row_key = {row_year, {(MONTH_BITS + DAY_BITS){1'b0}}};
            GRAN_MONTH: row_key = {row_year, row_month, {DAY_BITS{1'b0}}};
            default:    row_key = {row_year, row_month, row_day};
          endcase
          if (row_key < start_cfg) begin
            if (!have_period) open_mean = row_mean;
            if (row_last) begin
              if (have_period) push_candle(1'b1);
              clear_period();
            end
          end else if (row_key > end_cfg) begin
            if (have_period) push_candle(1'b1);
            if (row_last) clear_period();
            else stopped = 1'b1;
          end else begin
            if (have_period && row_key != cur_key) begin
              push_candle(1'b0);
              open_mean = period_close();
              clear_acc();
            end
            cur_key = row_key;
            have_period = 1'b1;
            if (row_low < low_acc) low_acc = row_low;
            if (row_high > high_acc) high_acc = row_high;
            // The count saturates; sum and count then hold.
            if (row_count != '1) begin
              mean_sum = mean_sum + (SB+CB)'(row_mean);
              row_count = row_count + 1'b1;
            end
            if (row_last) begin
              push_candle(1'b1);
              clear_period();
            end
          end
        end
      end

      if (m_tvalid && m_tready) begin
        candles_seen++;
        if (pending_candles.size() == 0) begin
          report($sformatf("candle %0d arrived with none expected", candles_seen));
        end else begin
          want = pending_candles.pop_front();
          check_field("period_key", 32'(m_tdata[0 +: KEY_BITS]), 32'(want.key));
          check_field("open_value", 32'(m_tdata[KEY_BITS +: SB]),
                      32'($unsigned(want.open_v)));
          check_field("high_out", 32'(m_tdata[KEY_BITS + SB +: SB]),
                      32'($unsigned(want.high_v)));
          check_field("low_out", 32'(m_tdata[KEY_BITS + 2*SB +: SB]),
                      32'($unsigned(want.low_v)));
          check_field("close_value", 32'(m_tdata[KEY_BITS + 3*SB +: SB]),
                      32'($unsigned(want.close_v)));
          check_field("country", 32'(m_tdata[KEY_BITS + 4*SB +: COUNTRY_BITS]),
                      32'(want.country));
          check_field("final_candle", 32'(m_tlast), 32'(want.last));
        end
      end

      if (finish_run && !flushed) begin
        flushed = 1'b1;
        foreach (pending_candles[i]) begin
          report($sformatf("candle for key %h never arrived", pending_candles[i].key));
        end
      end
    end
    pending <= pending_candles.size();
  end

endmodule

// ===== sim/tb_period_ohlc_aggregator_top.sv =====
`timescale 1ns / 1ps
module tb_period_ohlc_aggregator_top;
  import poa_pkg::*;

  localparam int SB       = SAMPLE_BITS_DEFAULT;
  localparam int ROW_W    = ((KEY_BITS + 3*SB + 7) / 8) * 8;
  localparam int CANDLE_W = ((KEY_BITS + 4*SB + COUNTRY_BITS + 7) / 8) * 8;

  // Two candles per row, each a full divide, plus some slack.
  localparam int SETTLE_CYCLES = 2 * (SB + 5) + 16;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int LONG_ROWS     = 40;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ROWS    = 60;

  localparam logic [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

  // The spare granularity code behaves like day.
  localparam logic [GRAN_BITS-1:0] GRAN_SPARE = 2'd3;
  localparam logic [COUNTRY_BITS-1:0] COUNTRY_TOP = '1;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [ROW_W-1:0] s_tdata;     // year, month, day, low_value, high_value, mean_value
  logic s_tlast;
  logic m_tvalid;
  logic m_tready;
  logic [CANDLE_W-1:0] m_tdata;  // period_key, open_value, high_out, low_out, close_value, country
  logic m_tlast;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic pready;
  logic finish_run;

  int fail_count;
  int pending;
  int candles_seen;
  int rows_sent;
  int settings_used;
  int cur_y;
  int cur_m;
  int cur_d;
  bit in_gaps_on;
  bit out_gaps_on;

  logic [GRAN_BITS-1:0] gran_codes[4] = '{GRAN_YEAR, GRAN_MONTH, GRAN_DAY, GRAN_SPARE};

  period_ohlc_aggregator_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  period_ohlc_checker candle_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .finish_run(finish_run),
    .fail_count(fail_count), .pending(pending), .candles_seen(candles_seen)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #10000000;
    $display("timeout: the block stopped making progress");
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [KEY_BITS-1:0] date_key(input int y, input int m, input int d);
    return {YEAR_BITS'(y), MONTH_BITS'(m), DAY_BITS'(d)};
  endfunction

  function automatic logic [SB-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0: return S_MIN;
      1: return S_MAX;
      default: return SB'($urandom);
    endcase
  endfunction

  task automatic send_row(input int y, input int m, input int d, input logic [SB-1:0] lo,
                          input logic [SB-1:0] hi, input logic [SB-1:0] mean,
                          input logic last);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ROW_W'({mean, hi, lo, DAY_BITS'(d), MONTH_BITS'(m), YEAR_BITS'(y)});
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    rows_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_BITS-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Waits until every predicted candle has been taken, then lets the divider finish.
  task automatic wait_idle();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [GRAN_BITS-1:0] gran, input logic [KEY_BITS-1:0] first,
                            input logic [KEY_BITS-1:0] last_key,
                            input logic [COUNTRY_BITS-1:0] country);
    wait_idle();
    write_reg(REG_GRANULARITY, CFG_DATA_BITS'(gran));
    write_reg(REG_START_KEY, CFG_DATA_BITS'(first));
    write_reg(REG_END_KEY, CFG_DATA_BITS'(last_key));
    write_reg(REG_COUNTRY, CFG_DATA_BITS'(country));
    settings_used++;
  endtask

  // One data set: dates walk forward from the current date, with some malformed rows mixed in.
  task automatic send_dataset(input int n_rows);
    for (int i = 0; i < n_rows; i++) begin
      if ($urandom_range(0, 99) < 12) begin
        send_row($urandom_range(0, (1 << YEAR_BITS) - 1), $urandom_range(0, 15),
                 $urandom_range(0, 31), draw_sample(), draw_sample(), draw_sample(),
                 i == n_rows - 1);
      end else begin
        case ($urandom_range(0, 11))
          0, 1, 2, 3, 4: ;
          5, 6, 7: begin
            cur_d++;
            if (cur_d > 28) begin
              cur_d = 1;
              cur_m++;
            end
          end
          8, 9: begin
            cur_m++;
            cur_d = $urandom_range(1, 31);
          end
          10: cur_y++;
          default: begin
            cur_y += $urandom_range(1, 3);
            cur_m = $urandom_range(1, 12);
          end
        endcase
        if (cur_m > 12) begin
          cur_m = 1;
          cur_y++;
        end
        if (cur_y > 9999) cur_y = 0;
        send_row(cur_y, cur_m, cur_d, draw_sample(), draw_sample(), draw_sample(),
                 i == n_rows - 1);
      end
    end
  endtask

  task automatic random_phase(input int row_budget);
    int y0;
    int m0;
    int d0;
    int sent;
    int n;
    logic [KEY_BITS-1:0] first;
    logic [KEY_BITS-1:0] last_key;
    logic [COUNTRY_BITS-1:0] country;
    y0 = $urandom_range(0, 9990);
    m0 = $urandom_range(1, 12);
    d0 = $urandom_range(1, 28);
    first = ($urandom_range(0, 4) == 0) ? START_KEY_RESET :
            date_key(y0, m0, d0 + $urandom_range(0, 3));
    last_key = ($urandom_range(0, 3) == 0) ? END_KEY_RESET :
               date_key(y0 + $urandom_range(0, 2), $urandom_range(1, 12),
                        $urandom_range(1, 31));
    case ($urandom_range(0, 3))
      0: country = '0;
      1: country = COUNTRY_TOP;
      default: country = COUNTRY_BITS'($urandom);
    endcase
    set_config(gran_codes[2'($urandom_range(0, 3))], first, last_key, country);
    sent = 0;
    while (sent < row_budget) begin
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
      cur_y = y0;
      cur_m = m0;
      cur_d = d0;
      in_gaps_on = ($urandom_range(0, 3) != 0);
      out_gaps_on = ($urandom_range(0, 3) != 0);
      send_dataset(n);
      sent += n;
    end
  endtask

  // Candle side: while out_gaps_on is set, holds m_tready low for a random stall before taking each candle.
  initial begin
    int stall;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = out_gaps_on ? $urandom_range(0, 8) : 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    finish_run <= 1'b0;
    rows_sent = 0;
    settings_used = 1;
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: day periods over keys from 0 up to the date 9999-12-31.
    // Sample extremes and a close that truncates toward zero (-7 / 2).
    send_row(0, 1, 1, S_MIN, S_MIN, -SB'(3), 1'b0);
    send_row(0, 1, 1, S_MAX, S_MAX, -SB'(4), 1'b0);
    send_row(0, 1, 2, S_MAX, S_MIN, S_MAX, 1'b0);
    send_row(0, 1, 2, S_MIN, S_MAX, S_MIN, 1'b1);
    // A data set of one row, sitting exactly on the end key.
    send_row(9999, 12, 31, S_MIN, S_MAX, S_MAX, 1'b1);
    // Dates outside the calendar, then a row past the end key and rows dropped after it.
    send_row(5, 0, 0, SB'(10), SB'(20), SB'(15), 1'b0);
    send_row(5, 15, 31, SB'(5), SB'(25), SB'(16), 1'b0);
    send_row(5, 15, 31, SB'(6), SB'(26), SB'(17), 1'b0);
    send_row((1 << YEAR_BITS) - 1, 15, 31, S_MIN, S_MAX, S_MIN, 1'b0);
    send_row(1, 1, 1, S_MIN, S_MAX, S_MAX, 1'b0);
    send_row(1, 1, 1, S_MIN, S_MAX, S_MAX, 1'b1);

    // Spare granularity code, a short window and the largest country tag.
    set_config(GRAN_SPARE, date_key(100, 6, 10), date_key(100, 6, 20), COUNTRY_TOP);
    send_row(100, 6, 1, SB'(40), SB'(60), SB'(50), 1'b0);
    send_row(100, 6, 5, SB'(60), SB'(80), SB'(70), 1'b0);
    send_row(100, 6, 10, SB'(90), SB'(110), SB'(100), 1'b0);
    // An early row after the period began must not move the opening value.
    send_row(100, 6, 3, S_MIN, S_MAX, S_MIN, 1'b0);
    send_row(100, 6, 12, -SB'(9), SB'(9), -SB'(5), 1'b0);
    send_row(100, 6, 25, SB'(1), SB'(2), SB'(3), 1'b0);
    send_row(100, 6, 26, SB'(1), SB'(2), SB'(3), 1'b1);
    // End of data on an early row, with and without an open period, then past the end key.
    send_row(100, 6, 15, SB'(7), SB'(8), SB'(9), 1'b0);
    send_row(100, 6, 1, SB'(7), SB'(8), SB'(9), 1'b1);
    send_row(100, 6, 1, SB'(7), SB'(8), SB'(9), 1'b1);
    send_row(100, 7, 1, SB'(7), SB'(8), SB'(9), 1'b1);

    // Start key above end key: nothing is ever in range.
    set_config(GRAN_MONTH, END_KEY_RESET, START_KEY_RESET, '0);
    send_row(250, 3, 3, SB'(1), SB'(2), SB'(3), 1'b0);
    send_row(9999, 12, 31, SB'(1), SB'(2), SB'(3), 1'b0);
    send_row(5, 5, 5, SB'(1), SB'(2), SB'(3), 1'b1);

    // One long year period built from many back-to-back rows.
    set_config(GRAN_YEAR, START_KEY_RESET, END_KEY_RESET, COUNTRY_BITS'(17));
    in_gaps_on = 1'b0;
    out_gaps_on = 1'b0;
    for (int i = 0; i < LONG_ROWS; i++) begin
      send_row(1234, 5, 6, SB'(0), SB'(0), SB'(100), 1'b0);
    end
    for (int i = 0; i < 5; i++) begin
      send_row(1234, 5 + i, 6, S_MIN, S_MAX, S_MIN, i == 4);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_phase(PHASE_ROWS);
    end

    wait_idle();
    finish_run <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Rows sent: %0d under %0d register settings; candles compared: %0d.",
             rows_sent, settings_used, candles_seen);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/poa_pkg.sv
sv/poa_div.sv
sv/poa_dp.sv
sv/poa_ctrl.sv
sv/period_ohlc_aggregator_top.sv
sim/period_ohlc_checker.sv
sim/tb_period_ohlc_aggregator_top.sv
